// File: sv/gesd_pkg.sv
// Package for the Gregorian to Ethiopian day stepper: types, constants and
// the per-year and per-month helper functions.
// No dependencies.
`default_nettype none

package gesd_pkg;

   // field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int WDAY_W   = 3;
   localparam int CSR_W    = 16;
   localparam int REQ_W    = 8;
   localparam int RSP_W    = 24;

   localparam logic [YEAR_W-1:0] RESET_YEAR  = 14'd2000;
   localparam logic [YEAR_W-1:0] REFORM_YEAR = 14'd1752;
   localparam logic [YEAR_W-1:0] EARLY_YEAR  = 14'd1900;
   localparam logic [YEAR_W-1:0] LATE_YEAR   = 14'd2100;
   localparam logic [YEAR_W-1:0] FIRST_ETH_YEAR = 14'd8;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [MONTH_W-1:0] ETH_PAGUME = 4'd13;

   localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd6;

   // terms that depend on the configured year only
   typedef struct packed {
      logic                leap_this;
      logic                leap_next;
      logic                is_reform;
      logic                eth_valid;
      logic [WDAY_W-1:0]   start_base;
      logic [MONTH_W-1:0]  jan1_eth_month;
      logic [DAY_W-1:0]    jan1_eth_day;
   } year_terms_type;

   // running calendar position
   typedef struct packed {
      logic [MONTH_W-1:0]  greg_month;
      logic [DAY_W-1:0]    greg_day;
      logic [WDAY_W-1:0]   weekday;
      logic [MONTH_W-1:0]  eth_month;
      logic [DAY_W-1:0]    eth_day;
   } day_state_type;

   // residue mod 7 of an 8-bit value (8 is 1 mod 7, so fold octal digits)
   function automatic logic [WDAY_W-1:0] mod7(input logic [7:0] v);
      logic [4:0] f;
      f = 5'(v[7:6]) + 5'(v[5:3]) + 5'(v[2:0]);
      if (f >= 5'd14) begin
         f = f - 5'd14;
      end else if (f >= 5'd7) begin
         f = f - 5'd7;
      end
      return f[WDAY_W-1:0];
   endfunction

   function automatic logic [WDAY_W-1:0] month_code(input logic [MONTH_W-1:0] m);
      logic [WDAY_W-1:0] c;
      unique case (m) inside
         4'd2, 4'd3, 4'd11: c = 3'd3;
         4'd4, 4'd7:        c = 3'd6;
         4'd5:              c = 3'd1;
         4'd6:              c = 3'd4;
         4'd8:              c = 3'd2;
         4'd9, 4'd12:       c = 3'd5;
         default:           c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap,
                                                  input logic reform);
      logic [DAY_W-1:0] len;
      unique case (m) inside
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         MONTH_FEB: len = 5'd28;
         default:   len = 5'd31;
      endcase
      if (m == MONTH_FEB && leap) begin
         len = 5'd29;
      end
      if (m == MONTH_SEP && reform) begin
         len = 5'd19;
      end
      return len;
   endfunction

   // weekday of the first of month m
   function automatic logic [WDAY_W-1:0] month_start(input logic [WDAY_W-1:0] base,
                                                     input logic leap,
                                                     input logic [MONTH_W-1:0] m);
      logic [7:0] v;
      v = 8'(base) + 8'(month_code(m));
      if (leap && m <= MONTH_FEB) begin
         v = v + 8'd6;
      end
      return mod7(v);
   endfunction

   // all year terms from one year value
   function automatic year_terms_type derive_year(input logic [YEAR_W-1:0] y);
      year_terms_type t;
      logic [26:0]       prod;
      logic [7:0]        hi;
      logic [YEAR_W-1:0] lo_full;
      logic [6:0]        lo;
      logic              jul;
      logic [4:0]        cc;
      logic [7:0]        sum;
      logic [DAY_W-1:0]  base;
      // y / 100 by reciprocal, exact over the 14-bit range
      prod    = 27'(y) * 27'd5243;
      hi      = prod[26:19];
      lo_full = y - 14'(hi) * 14'd100;
      lo      = lo_full[6:0];
      jul     = (y <= REFORM_YEAR);
      if (jul) begin
         t.leap_this = (y[1:0] == 2'd0);
         t.leap_next = (y[1:0] == 2'd3);
         cc          = 5'(8'd18 - hi);
      end else begin
         t.leap_this = (y[1:0] == 2'd0) && (lo != 7'd0 || hi[1:0] == 2'd0);
         t.leap_next = (y[1:0] == 2'd3) && (lo != 7'd99 || hi[1:0] == 2'd3);
         cc          = 5'({1'b0, ~hi[1:0]}) << 1;
      end
      sum          = 8'(lo) + 8'(lo[6:2]) + 8'(cc) + 8'd1;
      t.start_base = mod7(sum);
      t.is_reform  = (y == REFORM_YEAR);
      t.eth_valid  = (y > FIRST_ETH_YEAR);
      // ethiopian seed for january 1
      base = t.leap_this ? 5'd22 : 5'd23;
      if (jul) begin
         t.jan1_eth_month = 4'd5;
         t.jan1_eth_day   = 5'd6;
      end else begin
         t.jan1_eth_month = 4'd4;
         if (y < EARLY_YEAR) begin
            t.jan1_eth_day = base + 5'd1;
         end else if (y > LATE_YEAR) begin
            t.jan1_eth_day = base - 5'd1;
         end else begin
            t.jan1_eth_day = base;
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// File: sv/gregorian_to_ethiopian_day_stepper_unit.sv
// Top level of the Gregorian to Ethiopian day stepper.
// Depends on gesd_pkg for the year terms, month tables and state types.
`default_nettype none

// Each req transaction either restarts the configured year at January 1
// (restart bit set, or the first transaction after reset) or advances one
// day, and yields exactly one rsp transaction carrying the new day. One
// transaction is taken per clock; the result appears in an output register in
// the cycle after acceptance, and req_tready stays high while that
// register is empty or being drained, so the loop through the day counters
// (one month-length compare and increment) sets the rate of one day per
// cycle. A csr write (always ready) stores the year and, in the same cycle,
// its derived leap, weekday and Ethiopian seed terms, so the next day step
// may follow directly. There is no clearing pass after reset.
module gregorian_to_ethiopian_day_stepper_unit
   import gesd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // configuration write: [13:0] target_year
   input  wire logic             csr_tvalid,
   output logic                  csr_tready,
   input  wire logic [CSR_W-1:0] csr_tdata,
   // request: [0] restart
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   // response: [3:0] greg_month, [8:4] greg_day_label, [11:9] weekday,
   //           [15:12] eth_month, [20:16] eth_day
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   // response user: [0] eth_valid
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   year_terms_type   year_ff;
   year_terms_type   year_in;
   day_state_type    day_ff;
   day_state_type    day_in;
   logic             started_ff;
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] rsp_data_in;
   logic             rsp_user_ff;
   logic             rsp_last_ff;
   logic             rsp_last_in;
   logic             req_fire;
   logic             csr_fire;
   logic             restart;
   logic [DAY_W-1:0] cur_len;
   logic             month_end;
   logic             go_jan1;
   logic [DAY_W-1:0] eth_day_inc;
   logic [DAY_W-1:0] eth_limit;
   logic [DAY_W-1:0] label;
   logic [MONTH_W-1:0] eth_month_out;
   logic [DAY_W-1:0]   eth_day_out;

   // handshakes
   assign csr_tready = 1'b1;
   assign csr_fire   = csr_tvalid && csr_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign restart    = req_tdata[0];

   // year terms from the reset year or the written year
   assign year_in = derive_year(reset ? RESET_YEAR : csr_tdata[YEAR_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset || csr_fire) begin
         year_ff <= year_in;
      end
   end

   // next day
   always_comb begin
      day_in      = day_ff;
      cur_len     = month_len(day_ff.greg_month, year_ff.leap_this, year_ff.is_reform);
      month_end   = (day_ff.greg_day >= cur_len);
      go_jan1     = restart || !started_ff || (month_end && day_ff.greg_month >= MONTH_DEC);
      eth_day_inc = day_ff.eth_day + 5'd1;
      eth_limit   = year_ff.leap_next ? 5'd7 : 5'd6;
      if (go_jan1) begin
         day_in.greg_month = MONTH_JAN;
         day_in.greg_day   = 5'd1;
         day_in.weekday    = month_start(year_ff.start_base, year_ff.leap_this, MONTH_JAN);
         day_in.eth_month  = year_ff.jan1_eth_month;
         day_in.eth_day    = year_ff.jan1_eth_day;
      end else begin
         if (month_end) begin
            day_in.greg_month = day_ff.greg_month + 4'd1;
            day_in.greg_day   = 5'd1;
            day_in.weekday    = month_start(year_ff.start_base, year_ff.leap_this,
                                            day_ff.greg_month + 4'd1);
         end else begin
            day_in.greg_day = day_ff.greg_day + 5'd1;
            day_in.weekday  = (day_ff.weekday == WDAY_SAT) ? 3'd0 : day_ff.weekday + 3'd1;
         end
         // ethiopian counter: pagume ends early, other months at 30
         if (day_ff.eth_month >= ETH_PAGUME && eth_day_inc >= eth_limit) begin
            day_in.eth_day   = 5'd1;
            day_in.eth_month = 4'd1;
         end else if (eth_day_inc > 5'd30) begin
            day_in.eth_day   = 5'd1;
            day_in.eth_month = day_ff.eth_month + 4'd1;
         end else begin
            day_in.eth_day = eth_day_inc;
         end
      end
   end

   // result fields from the new day
   always_comb begin
      label = day_in.greg_day;
      if (year_ff.is_reform && day_in.greg_month == MONTH_SEP && day_in.greg_day >= 5'd3) begin
         label = day_in.greg_day + 5'd11;
      end
      eth_month_out = year_ff.eth_valid ? day_in.eth_month : 4'd0;
      eth_day_out   = year_ff.eth_valid ? day_in.eth_day : 5'd0;
      rsp_data_in   = {3'd0, eth_day_out, eth_month_out, day_in.weekday, label,
                       day_in.greg_month};
      rsp_last_in   = (day_in.greg_month == MONTH_DEC) && (day_in.greg_day >= 5'd31);
   end

   // day state
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff        <= 1'b0;
         day_ff.greg_month <= MONTH_JAN;
         day_ff.greg_day   <= 5'd1;
         day_ff.weekday    <= 3'd0;
         day_ff.eth_month  <= 4'd4;
         day_ff.eth_day    <= 5'd23;
      end else if (req_fire) begin
         started_ff <= 1'b1;
         day_ff     <= day_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= year_ff.eth_valid;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      day_ff.greg_month >= MONTH_JAN && day_ff.greg_month <= MONTH_DEC)
      else $error("gregorian month out of range");

   a_eth_day_range: assert property (@(posedge clock) disable iff (reset)
      day_ff.eth_day != 5'd0 && day_ff.eth_day <= 5'd30)
      else $error("ethiopian day out of range");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff && rsp_data_ff == $past(rsp_data_in))
      else $error("accepted day not registered as result");

   a_last_in_december: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_data_ff[MONTH_W-1:0] == MONTH_DEC)
      else $error("last day flagged outside december");

endmodule

`default_nettype wire

// File: tb/tb_gregorian_to_ethiopian_day_stepper_unit.sv
// Self-checking testbench for the Gregorian to Ethiopian day stepper: a directed
// table and then random year walks, each result checked against a table value or a calendar predictor.
// Depends on gesd_pkg and gregorian_to_ethiopian_day_stepper_unit.
`default_nettype none

module tb_gregorian_to_ethiopian_day_stepper_unit;
   import gesd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_ITEMS    = 1400;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int DRAIN_CYCLES    = 8;
   localparam int ETH_MONTH_DAYS  = 30;
   localparam int REFORM_SHIFT    = 11;
   localparam int REFORM_GAP_DAY  = 3;

   localparam logic DAY_ADVANCE = 1'b0;
   localparam logic DAY_RESTART = 1'b1;
   localparam logic [WDAY_W-1:0] WDAY_SUN = 3'd0;

   typedef struct packed {
      logic [MONTH_W-1:0] greg_month;
      logic [DAY_W-1:0]   day_label;
      logic [WDAY_W-1:0]  weekday;
      logic [MONTH_W-1:0] eth_month;
      logic [DAY_W-1:0]   eth_day;
      logic               eth_valid;
      logic               last_day;
   } day_rsp_type;

   typedef enum logic {ROW_YEAR, ROW_DAY} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [CSR_W-1:0] value;
      logic             known;
      day_rsp_type      want;
   } plan_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_tvalid = 1'b0;
   logic             csr_tready;
   logic [CSR_W-1:0] csr_tdata = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;

   day_rsp_type  day_q[$];
   plan_row_type plan[$];
   int        mismatches = 0;
   int        cycle_count = 0;
   bit        calm = 1'b0;
   bit        hold_off = 1'b0;

   // predictor copy of the calendar position and year
   int cal_year = RESET_YEAR;
   bit cal_started = 1'b0;
   int cal_gm, cal_gd, cal_wd, cal_em, cal_ed;

   int month_key [12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
   int month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   gregorian_to_ethiopian_day_stepper_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------- calendar predictor ----------------

   function automatic bit is_julian(input int y);
      return y <= REFORM_YEAR;
   endfunction

   function automatic bit is_greg_leap(input int y);
      return (y % 4 == 0) && (y % 100 != 0 || y % 400 == 0);
   endfunction

   function automatic bit leap_of(input int y);
      return is_julian(y) ? (y % 4 == 0) : is_greg_leap(y);
   endfunction

   function automatic bit leap_following(input int y);
      return is_julian(y) ? ((y + 1) % 4 == 0) : is_greg_leap(y + 1);
   endfunction

   function automatic int days_in_month(input int y, input int m);
      int len;
      len = month_days[m - 1];
      if (m == MONTH_FEB && leap_of(y)) len = 29;
      if (m == MONTH_SEP && y == REFORM_YEAR) len = 19;
      return len;
   endfunction

   // weekday of the first of month m from year, month and century codes
   function automatic int first_weekday(input int y, input int m);
      int hi, lo, yc, cc, sum;
      hi = y / 100;
      lo = y % 100;
      yc = (lo + lo / 4) % 7;
      cc = is_julian(y) ? (18 - hi) % 7 : (3 - hi % 4) * 2;
      sum = yc + month_key[m - 1] + cc + 1;
      if (leap_of(y) && m <= MONTH_FEB) sum = sum - 1;
      return sum % 7;
   endfunction

   // january 1 with the era-dependent ethiopian seed
   function automatic void go_new_year();
      int base;
      cal_gm = MONTH_JAN;
      cal_gd = 1;
      cal_wd = first_weekday(cal_year, MONTH_JAN);
      if (is_julian(cal_year)) begin
         cal_em = 5;
         cal_ed = 6;
      end else begin
         base = leap_of(cal_year) ? 22 : 23;
         cal_em = 4;
         if (cal_year < EARLY_YEAR) cal_ed = base + 1;
         else if (cal_year > LATE_YEAR) cal_ed = base - 1;
         else cal_ed = base;
      end
   endfunction

   function automatic void next_day();
      int pagume_end;
      if (cal_gd >= days_in_month(cal_year, cal_gm)) begin
         if (cal_gm >= MONTH_DEC) begin
            go_new_year();
            return;
         end
         cal_gm = cal_gm + 1;
         cal_gd = 1;
         cal_wd = first_weekday(cal_year, cal_gm);
      end else begin
         cal_gd = cal_gd + 1;
         cal_wd = (cal_wd + 1) % 7;
      end
      cal_ed = cal_ed + 1;
      pagume_end = leap_following(cal_year) ? 7 : 6;
      if (cal_em >= ETH_PAGUME && cal_ed >= pagume_end) begin
         cal_ed = 1;
         cal_em = 1;
      end
      if (cal_ed > ETH_MONTH_DAYS) begin
         cal_ed = 1;
         cal_em = cal_em + 1;
      end
   endfunction

   function automatic day_rsp_type predict_day(input logic rst);
      day_rsp_type r;
      int label;
      bit shown;
      if (rst == DAY_RESTART || !cal_started) begin
         go_new_year();
         cal_started = 1'b1;
      end else begin
         next_day();
      end
      label = cal_gd;
      if (cal_year == REFORM_YEAR && cal_gm == MONTH_SEP && cal_gd >= REFORM_GAP_DAY)
         label = label + REFORM_SHIFT;
      shown = cal_year > FIRST_ETH_YEAR;
      r.greg_month = MONTH_W'(cal_gm);
      r.day_label  = DAY_W'(label);
      r.weekday    = WDAY_W'(cal_wd);
      r.eth_month  = shown ? MONTH_W'(cal_em) : '0;
      r.eth_day    = shown ? DAY_W'(cal_ed) : '0;
      r.eth_valid  = shown;
      r.last_day   = (cal_gm == MONTH_DEC && cal_gd >= 31);
      return r;
   endfunction

   // ---------------- stimulus ----------------

   // sender gap: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_year();
      int y;
      case ($urandom_range(0, 9))
         0: y = REFORM_YEAR;
         1: begin
            case ($urandom_range(0, 5))
               0: y = 0;
               1: y = 1;
               2: y = FIRST_ETH_YEAR;
               3: y = FIRST_ETH_YEAR + 1;
               4: y = 9999;
               default: y = 16383;
            endcase
         end
         2: begin
            case ($urandom_range(0, 5))
               0: y = REFORM_YEAR - 1;
               1: y = REFORM_YEAR + 1;
               2: y = EARLY_YEAR - 1;
               3: y = EARLY_YEAR;
               4: y = LATE_YEAR;
               default: y = LATE_YEAR + 1;
            endcase
         end
         // years just before a leap year give the six-day pagume
         3, 4: y = $urandom_range(438, 2499) * 4 + 3;
         9: y = $urandom_range(0, 16383);
         default: y = $urandom_range(1, 9999);
      endcase
      return y;
   endfunction

   // one day transaction, expectation queued when first offered
   task automatic send_day(input logic rst, input logic known, input day_rsp_type known_val);
      int n;
      day_rsp_type want;
      n = pick_gap();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      want = predict_day(rst);
      day_q.push_back(known ? known_val : want);
      req_tdata <= {{(REQ_W-1){1'b0}}, rst};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // year write only once every queued day has come back
   task automatic write_year(input logic [CSR_W-1:0] v);
      req_tvalid <= 1'b0;
      while (day_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_tdata <= v;
      csr_tvalid <= 1'b1;
      do @(posedge clock); while (!(csr_tvalid && csr_tready));
      csr_tvalid <= 1'b0;
      cal_year = v[YEAR_W-1:0];
   endtask

   initial begin : stimulus
      int sent, phase, span, yr, i;
      bit long_run;
      logic rst;

      // directed table: defaults, early and late years, era edges, masked upper bits
      plan.push_back('{ROW_DAY, 16'(DAY_ADVANCE), 1'b1,
                       '{MONTH_JAN, 5'd1, WDAY_SAT, 4'd4, 5'd22, 1'b1, 1'b0}});
      plan.push_back('{ROW_DAY, 16'(DAY_ADVANCE), 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_RESTART), 1'b1,
                       '{MONTH_JAN, 5'd1, WDAY_SAT, 4'd4, 5'd22, 1'b1, 1'b0}});
      plan.push_back('{ROW_YEAR, 16'(FIRST_ETH_YEAR), 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_RESTART), 1'b1,
                       '{MONTH_JAN, 5'd1, WDAY_SUN, 4'd0, 5'd0, 1'b0, 1'b0}});
      plan.push_back('{ROW_DAY, 16'(DAY_ADVANCE), 1'b0, '0});
      plan.push_back('{ROW_YEAR, 16'd9, 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_RESTART), 1'b0, '0});
      plan.push_back('{ROW_YEAR, 16'd0, 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_RESTART), 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_ADVANCE), 1'b0, '0});
      plan.push_back('{ROW_YEAR, 16'd16383, 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_RESTART), 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_ADVANCE), 1'b0, '0});
      plan.push_back('{ROW_YEAR, 16'(REFORM_YEAR), 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_RESTART), 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_ADVANCE), 1'b0, '0});
      plan.push_back('{ROW_YEAR, 16'd1, 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_RESTART), 1'b0, '0});
      plan.push_back('{ROW_YEAR, 16'd9999, 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_RESTART), 1'b0, '0});
      plan.push_back('{ROW_YEAR, 16'(EARLY_YEAR - 1), 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_RESTART), 1'b0, '0});
      plan.push_back('{ROW_YEAR, 16'(EARLY_YEAR), 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_RESTART), 1'b0, '0});
      plan.push_back('{ROW_YEAR, 16'(LATE_YEAR + 1), 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_RESTART), 1'b0, '0});
      plan.push_back('{ROW_YEAR, 16'hC000 | 16'(RESET_YEAR), 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_ADVANCE), 1'b0, '0});
      plan.push_back('{ROW_DAY, 16'(DAY_ADVANCE), 1'b0, '0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_YEAR) write_year(plan[k].value);
         else send_day(plan[k].value[0], plan[k].known, plan[k].want);
      end

      // random walks: a reform year and a six-day pagume year in full, then mixed runs
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               yr = REFORM_YEAR;
               span = 360;
               long_run = 1'b1;
               calm = 1'b1;
            end
            1: begin
               yr = 2007;
               span = 370;
               long_run = 1'b1;
               calm = 1'b0;
            end
            default: begin
               yr = pick_year();
               long_run = ($urandom_range(0, 3) == 0);
               span = long_run ? $urandom_range(200, 400) : $urandom_range(1, 40);
               calm = ($urandom_range(0, 3) == 0);
            end
         endcase
         // keep the total near the item budget
         if (span > RANDOM_ITEMS - sent) span = RANDOM_ITEMS - sent;
         write_year({2'($urandom_range(0, 3)), 14'(yr)});
         for (i = 0; i < span; i++) begin
            if (phase == 0 && i == 30) hold_off = 1'b1;
            else if (phase > 1 && i == 10 && $urandom_range(0, 4) == 0) hold_off = 1'b1;
            if (i == 0) rst = (phase < 2) ? DAY_RESTART : 1'($urandom_range(0, 1));
            else if (phase < 2) rst = DAY_ADVANCE;
            else rst = ($urandom_range(0, long_run ? 199 : 9) == 0) ? DAY_RESTART : DAY_ADVANCE;
            send_day(rst, 1'b0, '0);
            sent++;
         end
         phase++;
      end

      // drain and report
      req_tvalid <= 1'b0;
      calm = 1'b0;
      while (day_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ---------------- result side ----------------

   // receiver pacing, with a long hold-off on request
   initial begin : rsp_pacing
      int n;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_tready <= 1'b0;
            n = HOLD_OFF_CYCLES;
         end else if (calm || $urandom_range(0, 99) < 55) begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 12);
         end else if ($urandom_range(0, 99) < 80) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 3);
         end else begin
            rsp_tready <= 1'b0;
            n = $urandom_range(10, 40);
         end
         repeat (n) @(posedge clock);
      end
   end

   // compare each day transaction with the oldest expectation
   always @(posedge clock) begin : rsp_check
      day_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.greg_month = rsp_tdata[3:0];
         got.day_label  = rsp_tdata[8:4];
         got.weekday    = rsp_tdata[11:9];
         got.eth_month  = rsp_tdata[15:12];
         got.eth_day    = rsp_tdata[20:16];
         got.eth_valid  = rsp_tuser;
         got.last_day   = rsp_tlast;
         if (day_q.size() == 0) begin
            if (mismatches < 10)
               $display("cycle %0d: unexpected day transaction, month %0d label %0d",
                        cycle_count, got.greg_month, got.day_label);
            mismatches++;
         end else begin
            want = day_q.pop_front();
            if (got.greg_month !== want.greg_month || got.day_label !== want.day_label ||
                got.weekday !== want.weekday || got.eth_month !== want.eth_month ||
                got.eth_day !== want.eth_day || got.eth_valid !== want.eth_valid ||
                got.last_day !== want.last_day) begin
               if (mismatches < 10) begin
                  $display("cycle %0d year %0d: got  mon %0d lbl %0d wd %0d eth %0d/%0d v %0d last %0d",
                           cycle_count, cal_year, got.greg_month, got.day_label, got.weekday,
                           got.eth_month, got.eth_day, got.eth_valid, got.last_day);
                  $display("   expected mon %0d lbl %0d wd %0d eth %0d/%0d v %0d last %0d",
                           want.greg_month, want.day_label, want.weekday,
                           want.eth_month, want.eth_day, want.eth_valid, want.last_day);
               end
               mismatches++;
            end
         end
      end
   end

endmodule

`default_nettype wire
